/* hw/rtl/ycr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ycr_pkg
// Shared constants, payload types and arithmetic helpers for the YCbCr to
// RGB pixel converter.
// ----------------------------------------------------------------------------
package ycr_pkg;

    localparam int MAX_PRECISION = 16;
    localparam int MIN_PRECISION = 8;

    // Color modes; the unused code behaves as RGB passthrough.
    localparam logic [1:0] MODE_YCBCR = 2'd0;
    localparam logic [1:0] MODE_RGB   = 2'd1;
    localparam logic [1:0] MODE_GRAY  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_COLOR_MODE  = 1'b0;
    localparam logic REG_SAMPLE_PREC = 1'b1;

    // Q16 matrix coefficients.
    localparam logic signed [17:0] COEF_CR_R = 18'sd91881;
    localparam logic signed [17:0] COEF_CB_G = 18'sd22553;
    localparam logic signed [17:0] COEF_CR_G = 18'sd46802;
    localparam logic signed [17:0] COEF_CB_B = 18'sd116130;
    localparam logic signed [17:0] CHROMA_OFFSET = 18'sd128;

    localparam int COMP_W  = 17;
    localparam int PROD_W  = 36;
    localparam int SUM_W   = 38;
    localparam int CHAN_W  = 22;
    localparam int LEVEL_W = MAX_PRECISION;
    localparam int PREC_W  = 5;

    typedef struct packed {
        logic signed [COMP_W-1:0] c0;
        logic signed [COMP_W-1:0] c1;
        logic signed [COMP_W-1:0] c2;
        logic                     last;
    } t_pixel;

    typedef struct packed {
        logic signed [PROD_W-1:0] cr_r;
        logic signed [PROD_W-1:0] cb_g;
        logic signed [PROD_W-1:0] cr_g;
        logic signed [PROD_W-1:0] cb_b;
    } t_products;

    typedef struct packed {
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] g;
        logic signed [SUM_W-1:0] b;
    } t_sums;

    typedef struct packed {
        logic [LEVEL_W-1:0] r;
        logic [LEVEL_W-1:0] g;
        logic [LEVEL_W-1:0] b;
        logic               last;
    } t_levels;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } t_rgb;

    // Divide a Q16 sum by 65536, truncating toward zero.
    function automatic logic signed [CHAN_W-1:0] tdiv16(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] biased;
        biased = s + (s[SUM_W-1] ? SUM_W'(65535) : SUM_W'(0));
        return biased[SUM_W-1:16];
    endfunction

    // Saturate a signed channel value to 0..maxv.
    function automatic logic [LEVEL_W-1:0] clamp_chan(input logic signed [CHAN_W-1:0] v,
                                                      input logic [LEVEL_W-1:0] maxv);
        logic [LEVEL_W-1:0] res;
        if (v[CHAN_W-1]) begin
            res = '0;
        end else if ($unsigned(v) > CHAN_W'(maxv)) begin
            res = maxv;
        end else begin
            res = v[LEVEL_W-1:0];
        end
        return res;
    endfunction

    // floor(v * 255 / (2^p - 1)) for v <= 2^p - 1. Since 2^p = M + 1, the
    // quotient is (x >> p) plus one more when the high part plus the low
    // part reaches M; that sum always stays below 2M.
    function automatic logic [7:0] scale_chan(input logic [LEVEL_W-1:0] v,
                                              input logic [PREC_W-1:0] p,
                                              input logic [LEVEL_W-1:0] maxv);
        logic [LEVEL_W+7:0] x;
        logic [LEVEL_W+7:0] hi;
        logic [LEVEL_W:0]   t;
        logic [7:0]         q;
        x  = {v, 8'd0} - (LEVEL_W+8)'(v);
        hi = x >> p;
        t  = (LEVEL_W+1)'(hi[7:0]) + (LEVEL_W+1)'(x[LEVEL_W-1:0] & maxv);
        q  = hi[7:0];
        if (t >= (LEVEL_W+1)'(maxv)) begin
            q = q + 8'd1;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ycr_matrix.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ycr_matrix
// Two pipeline stages of the color matrix: chroma products, then the Q16
// channel sums. Component values travel along for the passthrough modes.
// ----------------------------------------------------------------------------
module ycr_matrix (
    input  wire logic            i_clk,
    input  wire logic [1:0]      i_en,
    input  wire ycr_pkg::t_pixel i_pix,
    output ycr_pkg::t_pixel      o_pix,
    output ycr_pkg::t_sums       o_sums
);
    import ycr_pkg::*;

    t_pixel    r_pix1;
    t_products r_prod;
    t_pixel    r_pix2;
    t_sums     r_sums;

    logic signed [17:0]      d_b;
    logic signed [17:0]      d_r;
    t_products               n_prod;
    logic signed [SUM_W-1:0] base;
    t_sums                   n_sums;

    always_comb begin
        d_b = {i_pix.c1[COMP_W-1], i_pix.c1} - CHROMA_OFFSET;
        d_r = {i_pix.c2[COMP_W-1], i_pix.c2} - CHROMA_OFFSET;
        n_prod.cr_r = COEF_CR_R * d_r;
        n_prod.cb_g = COEF_CB_G * d_b;
        n_prod.cr_g = COEF_CR_G * d_r;
        n_prod.cb_b = COEF_CB_B * d_b;
    end

    always_comb begin
        base     = {{5{r_pix1.c0[COMP_W-1]}}, r_pix1.c0, 16'd0};
        n_sums.r = base + SUM_W'(r_prod.cr_r);
        n_sums.g = base - SUM_W'(r_prod.cb_g) - SUM_W'(r_prod.cr_g);
        n_sums.b = base + SUM_W'(r_prod.cb_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pix1 <= i_pix;
            r_prod <= n_prod;
        end
        if (i_en[1]) begin
            r_pix2 <= r_pix1;
            r_sums <= n_sums;
        end
    end

    assign o_pix  = r_pix2;
    assign o_sums = r_sums;

endmodule
`default_nettype wire

/* hw/rtl/ycr_clamp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ycr_clamp
// Selects matrix or passthrough values by color mode, removes the Q16
// fraction and saturates each channel to the sample range.
// ----------------------------------------------------------------------------
module ycr_clamp (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [1:0]                      i_mode,
    input  wire logic [ycr_pkg::LEVEL_W-1:0]     i_max,
    input  wire ycr_pkg::t_pixel                 i_pix,
    input  wire ycr_pkg::t_sums                  i_sums,
    output ycr_pkg::t_levels                     o_levels
);
    import ycr_pkg::*;

    t_levels                  r_levels;
    t_levels                  n_levels;
    logic signed [CHAN_W-1:0] v_r;
    logic signed [CHAN_W-1:0] v_g;
    logic signed [CHAN_W-1:0] v_b;
    logic signed [CHAN_W-1:0] x0;
    logic signed [CHAN_W-1:0] x1;
    logic signed [CHAN_W-1:0] x2;

    always_comb begin
        x0 = {{(CHAN_W-COMP_W){i_pix.c0[COMP_W-1]}}, i_pix.c0};
        x1 = {{(CHAN_W-COMP_W){i_pix.c1[COMP_W-1]}}, i_pix.c1};
        x2 = {{(CHAN_W-COMP_W){i_pix.c2[COMP_W-1]}}, i_pix.c2};
        case (i_mode)
            MODE_YCBCR: begin
                v_r = tdiv16(i_sums.r);
                v_g = tdiv16(i_sums.g);
                v_b = tdiv16(i_sums.b);
            end
            MODE_GRAY: begin
                v_r = x0;
                v_g = x0;
                v_b = x0;
            end
            default: begin
                v_r = x0;
                v_g = x1;
                v_b = x2;
            end
        endcase
        n_levels.r    = clamp_chan(v_r, i_max);
        n_levels.g    = clamp_chan(v_g, i_max);
        n_levels.b    = clamp_chan(v_b, i_max);
        n_levels.last = i_pix.last;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_levels <= n_levels;
        end
    end

    assign o_levels = r_levels;

endmodule
`default_nettype wire

/* hw/rtl/ycr_scale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ycr_scale
// Output stage: scales each saturated channel to 0..255.
// ----------------------------------------------------------------------------
module ycr_scale (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [ycr_pkg::PREC_W-1:0]  i_prec,
    input  wire logic [ycr_pkg::LEVEL_W-1:0] i_max,
    input  wire ycr_pkg::t_levels            i_levels,
    output ycr_pkg::t_rgb                    o_rgb
);
    import ycr_pkg::*;

    t_rgb r_rgb;
    t_rgb n_rgb;

    always_comb begin
        n_rgb.r    = scale_chan(i_levels.r, i_prec, i_max);
        n_rgb.g    = scale_chan(i_levels.g, i_prec, i_max);
        n_rgb.b    = scale_chan(i_levels.b, i_prec, i_max);
        n_rgb.last = i_levels.last;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule
`default_nettype wire

/* hw/rtl/ycbcr_to_rgb_pixel_converter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_pixel_converter
// Converts YCbCr, RGB or gray samples to 8-bit RGB with clamp and scaling.
// ----------------------------------------------------------------------------
// The converter accepts one pixel per clock while the output is not stalled;
// chroma multiply, Q16 sum, clamp and scale each take one register stage.
// Every stage holds its own valid bit and moves on whenever the stage after
// it is empty or advancing, so a stalled output fills the pipeline before the
// input side sees ready drop, and bubbles are squeezed out. The user must
// write registers through the plain write port (0: color mode, 1: sample
// precision) only while no pixel is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module ycbcr_to_rgb_pixel_converter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_idx,
    input  wire logic [ycr_pkg::PREC_W-1:0]         i_cfg_data,
    input  wire logic                               i_pix_valid,
    output logic                                    o_pix_ready,
    input  wire logic signed [ycr_pkg::COMP_W-1:0]  i_first_component,
    input  wire logic signed [ycr_pkg::COMP_W-1:0]  i_second_component,
    input  wire logic signed [ycr_pkg::COMP_W-1:0]  i_third_component,
    input  wire logic                               i_last_pixel,
    output logic                                    o_rgb_valid,
    input  wire logic                               i_rgb_ready,
    output logic [7:0]                              o_red_out,
    output logic [7:0]                              o_green_out,
    output logic [7:0]                              o_blue_out,
    output logic                                    o_last_out
);
    import ycr_pkg::*;

    localparam int STAGES = 4;

    logic [1:0]         r_mode;
    logic [PREC_W-1:0]  r_prec;
    logic [LEVEL_W-1:0] r_max;
    logic [1:0]         n_mode;
    logic [PREC_W-1:0]  n_prec;
    logic [LEVEL_W-1:0] n_max;
    logic [PREC_W-1:0]  wr_prec;

    logic [STAGES-1:0]  r_vld;
    logic [STAGES-1:0]  n_vld;
    logic [STAGES:0]    rdy;
    logic [STAGES:0]    vin;

    t_pixel  in_pix;
    t_pixel  mat_pix;
    t_sums   mat_sums;
    t_levels levels;
    t_rgb    rgb;

    // Configuration; precision is stored already limited to its legal range.
    always_comb begin
        n_mode  = r_mode;
        n_prec  = r_prec;
        n_max   = r_max;
        wr_prec = i_cfg_data;
        if (wr_prec < PREC_W'(MIN_PRECISION)) begin
            wr_prec = PREC_W'(MIN_PRECISION);
        end else if (wr_prec > PREC_W'(MAX_PRECISION)) begin
            wr_prec = PREC_W'(MAX_PRECISION);
        end
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COLOR_MODE: begin
                    n_mode = i_cfg_data[1:0];
                end
                REG_SAMPLE_PREC: begin
                    n_prec = wr_prec;
                    n_max  = LEVEL_W'(((LEVEL_W+1)'(1) << wr_prec) - (LEVEL_W+1)'(1));
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // Stage k loads when it is empty or its content moves on this cycle.
    always_comb begin
        rdy[STAGES] = i_rgb_ready;
        vin[0]      = i_pix_valid;
        for (int k = STAGES - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        for (int k = 0; k < STAGES; k++) begin
            vin[k+1] = r_vld[k];
            n_vld[k] = rdy[k] ? vin[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_YCBCR;
            r_prec <= PREC_W'(MIN_PRECISION);
            r_max  <= LEVEL_W'((1 << MIN_PRECISION) - 1);
            r_vld  <= '0;
        end else begin
            r_mode <= n_mode;
            r_prec <= n_prec;
            r_max  <= n_max;
            r_vld  <= n_vld;
        end
    end

    always_comb begin
        in_pix.c0   = i_first_component;
        in_pix.c1   = i_second_component;
        in_pix.c2   = i_third_component;
        in_pix.last = i_last_pixel;
    end

    ycr_matrix u_matrix (
        .i_clk  (i_clk),
        .i_en   (rdy[1:0]),
        .i_pix  (in_pix),
        .o_pix  (mat_pix),
        .o_sums (mat_sums)
    );

    ycr_clamp u_clamp (
        .i_clk    (i_clk),
        .i_en     (rdy[2]),
        .i_mode   (r_mode),
        .i_max    (r_max),
        .i_pix    (mat_pix),
        .i_sums   (mat_sums),
        .o_levels (levels)
    );

    ycr_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (rdy[3]),
        .i_prec   (r_prec),
        .i_max    (r_max),
        .i_levels (levels),
        .o_rgb    (rgb)
    );

    assign o_pix_ready = rdy[0];
    assign o_rgb_valid = r_vld[STAGES-1];
    assign o_red_out   = rgb.r;
    assign o_green_out = rgb.g;
    assign o_blue_out  = rgb.b;
    assign o_last_out  = rgb.last;

endmodule
`default_nettype wire

/* hw/rtl/ycr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ycr_checker
// Port-level checks of the pixel converter, bound to the top level.
// ----------------------------------------------------------------------------
module ycr_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               o_pix_ready,
    input  wire logic                               o_rgb_valid,
    input  wire logic                               i_rgb_ready,
    input  wire logic [7:0]                         o_red_out,
    input  wire logic [7:0]                         o_green_out,
    input  wire logic [7:0]                         o_blue_out,
    input  wire logic                               o_last_out
);

    // Nothing comes out in the cycle after a reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rgb_valid)
        else $error("result valid right after reset");

    // An empty output stage means the whole pipeline can take a pixel.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rgb_valid |-> o_pix_ready)
        else $error("input not ready while output stage is empty");

    // A result that waits for the sink stays and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rgb_valid && !i_rgb_ready |=> o_rgb_valid && $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out) && $stable(o_last_out))
        else $error("stalled result changed or dropped");

    // With the sink always ready, the input never stalls.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rgb_ready && $past(i_rgb_ready) && $past(i_rgb_ready, 2)
            && $past(i_rgb_ready, 3) && $past(i_rgb_ready, 4) |-> o_pix_ready)
        else $error("input stalled while output side was ready");

endmodule

bind ycbcr_to_rgb_pixel_converter ycr_checker u_ycr_checker (.*);
`default_nettype wire
